>>> hdl/ohf_pkg.sv
// ============================================================================
// ohf_pkg: shared types, widths and the Hamming coefficient table
// Holds the frame geometry, the controller-to-datapath command and status
// structs, and the elaboration-time build of the unsigned Q2.15 window table.
// ============================================================================
package ohf_pkg;

    // Frame geometry and field widths.
    localparam int WINDOW_LEN    = 64;
    localparam int IDX_W         = $clog2(WINDOW_LEN);
    localparam int FILL_W        = $clog2(WINDOW_LEN + 1);
    localparam int SAMPLE_W      = 16;
    localparam int FRAME_INDEX_W = 6;
    localparam int HOP_W         = 7;
    localparam int COEF_W        = 17;
    localparam int COEF_FRAC     = 15;
    localparam int PROD_W        = 32;

    localparam logic [HOP_W-1:0] HOP_RESET   = HOP_W'(32);
    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(WINDOW_LEN - 1);
    localparam logic [PROD_W-1:0] TRUNC_BIAS = PROD_W'((1 << COEF_FRAC) - 1);

    // Command from the controller to the datapath.
    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             rd_last;
    } ohf_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic adv;
    } ohf_status_t;

    // Coefficient table, built once at elaboration.
    typedef logic [COEF_W-1:0] coef_t;
    typedef coef_t coef_table_t [WINDOW_LEN];

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam int unsigned CoefD = (WINDOW_LEN > 1) ? WINDOW_LEN - 1 : 1;
    localparam longint unsigned TaylorDiv [7] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                                  64'd90, 64'd132, 64'd182};

    // Cosine of pi*2n/d in Q30, folded into the first quadrant, Taylor
    // series to degree 14 with each term truncated.
    function automatic longint cos_q30(input int unsigned n);
        longint unsigned m;
        longint unsigned k;
        longint unsigned a;
        longint unsigned a2;
        longint unsigned term;
        longint          sum;
        logic            neg;
        m   = 64'(n);
        neg = 1'b0;
        if (2 * m > 64'(CoefD))
            m = 64'(CoefD) - m;
        if (4 * m > 64'(CoefD))
        begin
            k   = 64'(CoefD) - 2 * m;
            neg = 1'b1;
        end
        else
        begin
            k = 2 * m;
        end
        a    = (PI_Q30 * k + 64'(CoefD / 2)) / CoefD;
        a2   = (a * a) >> 30;
        term = 64'd1 << 30;
        sum  = longint'(term);
        for (int i = 0; i < 7; i++)
        begin
            term = ((term * a2) >> 30) / TaylorDiv[i];
            if (i[0] == 1'b0)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        return neg ? -sum : sum;
    endfunction

    function automatic coef_t coef_value(input int unsigned n);
        longint c;
        longint v;
        c = cos_q30(n);
        v = longint'(54) * (longint'(1) << 30) - longint'(46) * c;
        if (v < 0)
            v = 0;
        return coef_t'((v + longint'(50 * 32768)) / (100 * 32768));
    endfunction

    function automatic coef_table_t coef_table_build();
        coef_table_t t;
        for (int n = 0; n < WINDOW_LEN; n++)
            t[n] = coef_value(n);
        return t;
    endfunction

    localparam coef_table_t COEF_TABLE = coef_table_build();

endpackage

>>> hdl/overlapped_hamming_framer.sv
// ============================================================================
// overlapped_hamming_framer: sliding window framer with Hamming weighting
// Collects signed 16-bit samples and, every hop_length samples, emits one
// frame of WINDOW_LEN Hamming-weighted samples, oldest first.
// ============================================================================
// Usage:
// Samples arrive on the sample_valid/sample_ready channel; each accepted
// request is one 16-bit sample. Results leave on result_valid/result_ready,
// one weighted sample per request with its frame_index and a frame_last mark
// on the final position of a frame. hop_length is written through
// cfg_write_en/cfg_write_data while the block is idle, a rule on the user
// that the block does not enforce; zero acts as one. Throughput: while idle,
// samples are taken one per cycle. A sample that completes a hop starts a
// readout of WINDOW_LEN (64) positions, one per cycle unless the receiver stalls,
// through the single window memory read port and multiplier, and no
// sample is taken during it. Pipeline: once a frame starts, each position
// passes the read, product and output registers. New samples are taken while
// the last results of a frame still drain from the pipeline.
// Reset: the window reads as all zeros, hop_length returns to 32 and the hop
// count to zero; no clearing pass is needed. A stalled receiver freezes the
// whole readout pipeline with its output held, and nothing is dropped.
// ============================================================================
module overlapped_hamming_framer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic signed [ohf_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic signed [ohf_pkg::SAMPLE_W-1:0] windowed_sample,
    output logic [ohf_pkg::FRAME_INDEX_W-1:0]   frame_index,
    output logic                                frame_last,
    input  logic                                cfg_write_en,
    input  logic [ohf_pkg::HOP_W-1:0]           cfg_write_data
);
    import ohf_pkg::*;

    // Commands flow from the controller; the datapath reports whether the
    // pipeline can advance this cycle.
    ohf_cmd_t    cmd;
    ohf_status_t status;

    ohf_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .status         (status),
        .cmd            (cmd)
    );

    ohf_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .sample_in       (sample_in),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .windowed_sample (windowed_sample),
        .frame_index     (frame_index),
        .frame_last      (frame_last)
    );

endmodule

>>> hdl/ohf_ctrl.sv
// ============================================================================
// ohf_ctrl: framer controller
// Owns the hop register and hop counter, accepts samples, and sequences the
// frame readout one position per cycle while the datapath can advance.
// ============================================================================
module ohf_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_valid,
    output logic                        sample_ready,
    input  logic                        cfg_write_en,
    input  logic [ohf_pkg::HOP_W-1:0]   cfg_write_data,
    input  ohf_pkg::ohf_status_t        status,
    output ohf_pkg::ohf_cmd_t           cmd
);
    import ohf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_FRAME = 2'b10
    } ohf_state_t;

    ohf_state_t       state_reg, state_next;
    logic [HOP_W-1:0] hop_length_reg;
    logic [HOP_W-1:0] hop_count_reg, hop_count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [HOP_W-1:0] hop_eff;
    logic [HOP_W-1:0] hop_count_inc;

    // A hop of zero behaves as a hop of one.
    assign hop_eff       = (hop_length_reg == '0) ? HOP_W'(1) : hop_length_reg;
    assign hop_count_inc = hop_count_reg + HOP_W'(1);
    assign sample_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        hop_count_next = hop_count_reg;
        idx_next       = idx_reg;
        cmd.wr_en      = 1'b0;
        cmd.rd_en      = 1'b0;
        cmd.rd_idx     = idx_reg;
        cmd.rd_last    = (idx_reg == LAST_IDX);
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.wr_en      = 1'b1;
                    hop_count_next = hop_count_inc;
                    if (hop_count_inc >= hop_eff)
                    begin
                        hop_count_next = '0;
                        idx_next       = '0;
                        state_next     = ST_FRAME;
                    end
                end
            end
            ST_FRAME:
            begin
                if (status.adv)
                begin
                    cmd.rd_en = 1'b1;
                    if (idx_reg == LAST_IDX)
                        state_next = ST_IDLE;
                    else
                        idx_next = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hop_length_reg <= HOP_RESET;
            hop_count_reg  <= '0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            hop_count_reg <= hop_count_next;
            idx_reg       <= idx_next;
            if (cfg_write_en)
                hop_length_reg <= cfg_write_data;
        end
    end

endmodule

>>> hdl/ohf_datapath.sv
// ============================================================================
// ohf_datapath: sample window and windowing pipeline
// Circular sample memory with a fill count standing in for its zero reset,
// then read, multiply and truncate stages that stall together on the output.
// ============================================================================
module ohf_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ohf_pkg::ohf_cmd_t                   cmd,
    output ohf_pkg::ohf_status_t                status,
    input  logic signed [ohf_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic signed [ohf_pkg::SAMPLE_W-1:0] windowed_sample,
    output logic [ohf_pkg::FRAME_INDEX_W-1:0]   frame_index,
    output logic                                frame_last
);
    import ohf_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [WINDOW_LEN];

    logic [IDX_W-1:0]  wp_reg, wp_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [IDX_W:0]    addr_sum;
    logic [IDX_W-1:0]  rd_addr;
    logic              rd_filled;
    logic              adv;

    // Stage 1: memory read and coefficient lookup.
    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_rdata_reg;
    logic                       s1_filled_reg;
    coef_t                      s1_coef_reg;
    logic [IDX_W-1:0]           s1_idx_reg;
    logic                       s1_last_reg;

    // Stage 2: product.
    logic                       s2_valid_reg;
    logic signed [PROD_W-1:0]   s2_prod_reg;
    logic [IDX_W-1:0]           s2_idx_reg;
    logic                       s2_last_reg;

    // Stage 3: output register.
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic [IDX_W-1:0]           out_idx_reg;
    logic                       out_last_reg;

    logic signed [SAMPLE_W-1:0]          x_masked;
    logic signed [SAMPLE_W+COEF_W:0]     prod_full;
    logic signed [PROD_W-1:0]            prod_biased;

    // The whole pipeline moves when the output register is free.
    assign adv        = !out_valid_reg || result_ready;
    assign status.adv = adv;

    // Oldest sample sits at the write pointer; wrap the offset once.
    assign addr_sum = {1'b0, wp_reg} + {1'b0, cmd.rd_idx};
    assign rd_addr  = (addr_sum >= (IDX_W+1)'(WINDOW_LEN))
                    ? IDX_W'(addr_sum - (IDX_W+1)'(WINDOW_LEN))
                    : addr_sum[IDX_W-1:0];
    // Slots not yet written since reset read as zero.
    assign rd_filled = (FILL_W'(rd_addr) < fill_reg);

    assign wp_next   = (wp_reg == LAST_IDX) ? '0 : wp_reg + IDX_W'(1);
    assign fill_next = (fill_reg == FILL_W'(WINDOW_LEN)) ? fill_reg
                                                        : fill_reg + FILL_W'(1);

    assign x_masked    = s1_filled_reg ? s1_rdata_reg : '0;
    assign prod_full   = x_masked * $signed({1'b0, s1_coef_reg});
    assign prod_biased = s2_prod_reg + (s2_prod_reg[PROD_W-1] ? TRUNC_BIAS : '0);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[wp_reg] <= sample_in;
        if (adv && cmd.rd_en)
            s1_rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                wp_reg   <= wp_next;
                fill_reg <= fill_next;
            end
            if (adv)
            begin
                s1_valid_reg  <= cmd.rd_en;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_filled_reg  <= rd_filled;
            s1_coef_reg    <= COEF_TABLE[cmd.rd_idx];
            s1_idx_reg     <= cmd.rd_idx;
            s1_last_reg    <= cmd.rd_last;
            s2_prod_reg    <= PROD_W'(prod_full);
            s2_idx_reg     <= s1_idx_reg;
            s2_last_reg    <= s1_last_reg;
            out_sample_reg <= prod_biased[COEF_FRAC+SAMPLE_W-1:COEF_FRAC];
            out_idx_reg    <= s2_idx_reg;
            out_last_reg   <= s2_last_reg;
        end
    end

    assign result_valid    = out_valid_reg;
    assign windowed_sample = out_sample_reg;
    assign frame_index     = FRAME_INDEX_W'(out_idx_reg);
    assign frame_last      = out_last_reg;

endmodule

>>> hdl/ohf_checker.sv
// ============================================================================
// ohf_checker: port-level checks for the framer
// Watches the top-level ports over time and is bound to the top level.
// ============================================================================
module ohf_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                result_valid,
    input logic                                result_ready,
    input logic signed [ohf_pkg::SAMPLE_W-1:0] windowed_sample,
    input logic [ohf_pkg::FRAME_INDEX_W-1:0]   frame_index,
    input logic                                frame_last
);
    import ohf_pkg::*;

    // No result is offered while reset is held.
    a_no_result_in_reset: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result offered during reset");

    // A stalled result keeps its contents.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid
            && $stable(windowed_sample) && $stable(frame_index) && $stable(frame_last))
        else $error("stalled result changed");

    // The last mark sits exactly on the final position of a frame.
    a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (frame_last == (frame_index == FRAME_INDEX_W'(WINDOW_LEN - 1))))
        else $error("frame_last does not match frame_index");

    // Within a frame the next position follows right after a taken result.
    a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !frame_last |=> result_valid
            && (frame_index == $past(frame_index) + FRAME_INDEX_W'(1)))
        else $error("frame readout broke off or skipped a position");

endmodule

bind overlapped_hamming_framer ohf_checker u_ohf_checker (.*);
